// ===== src/assert_macros.svh =====
// concurrent assertion helpers, clocked on clk and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define ASSERT_HOLDS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/lfu_pkg.sv =====
package lfu_pkg;

	localparam int NUM_SETS_DEF   = 64;
	localparam int NUM_WAYS_DEF   = 8;
	localparam int COUNT_BITS_DEF = 16;

	localparam int CMD_W        = 2;
	localparam int SET_IN_W     = 6;
	localparam int WAY_IN_W     = 3;
	localparam int MASK_W       = 8;
	localparam int LINE_COUNT_W = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_TOUCH  = 2'd0,
		CMD_VICTIM = 2'd1,
		CMD_RESET  = 2'd2
	} cmd_t;

endpackage

// ===== src/lfu_if.sv =====
interface lfu_req_if;
	import lfu_pkg::*;

	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [SET_IN_W-1:0] set_addr;
	logic [WAY_IN_W-1:0] way;
	logic [MASK_W-1:0]   valid_mask;

	modport source (output valid, cmd, set_addr, way, valid_mask, input ready);
	modport sink (input valid, cmd, set_addr, way, valid_mask, output ready);
endinterface

interface lfu_rsp_if;
	import lfu_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [WAY_IN_W-1:0]     victim_way;
	logic                    conflict;
	logic [LINE_COUNT_W-1:0] line_count;

	modport source (output valid, victim_way, conflict, line_count, input ready);
	modport sink (input valid, victim_way, conflict, line_count, output ready);
endinterface

// ===== src/lfu_lru_tiebreak_replacement.sv =====
// LFU replacement with LRU tiebreak. Per set, one memory row holds the tracked
// bit, use count and recency rank of every way. After reset a clearing pass
// writes one row per cycle over all NUM_SETS rows; no request is taken meanwhile.
// A request is accepted only when the sequencer is idle. The set row is read
// in the accept cycle, updated or examined in the next, and the result is
// registered and moved to the output register in the done state. Touch,
// reset and a victim query that finds an invalid way go from exec to done.
// A victim query with a conflict first walks the ways in the scan state
// through one shared count/rank comparator, one way per cycle. The output
// register holds a finished transaction until it is taken; the sequencer
// waits on it only when the next result is ready and the register is still full.
module lfu_lru_tiebreak_replacement #(
	parameter int NUM_SETS   = lfu_pkg::NUM_SETS_DEF,
	parameter int NUM_WAYS   = lfu_pkg::NUM_WAYS_DEF,
	parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	lfu_req_if.sink           req,
	lfu_rsp_if.source         rsp
);
	import lfu_pkg::*;

`include "assert_macros.svh"

	localparam int SET_AW   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WAY_BITS = $clog2(NUM_WAYS);
	localparam int MASK_LIM = (NUM_WAYS < MASK_W) ? NUM_WAYS : MASK_W;
	localparam int EXT_W    = COUNT_BITS + LINE_COUNT_W;

	typedef logic [NUM_WAYS-1:0]                 trk_row_t;
	typedef logic [NUM_WAYS-1:0][COUNT_BITS-1:0] cnt_row_t;
	typedef logic [NUM_WAYS-1:0][WAY_BITS-1:0]   rnk_row_t;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_EXEC  = 5'b00100,
		ST_SCAN  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	function automatic logic [LINE_COUNT_W-1:0] clip(input logic [COUNT_BITS-1:0] c);
		logic [EXT_W-1:0] ext;
		ext = EXT_W'(c);
		if (ext > EXT_W'({LINE_COUNT_W{1'b1}}))
			return '1;
		return ext[LINE_COUNT_W-1:0];
	endfunction

	trk_row_t mem_trk [NUM_SETS];
	cnt_row_t mem_cnt [NUM_SETS];
	rnk_row_t mem_rnk [NUM_SETS];

	state_t               state_q;
	logic [SET_AW-1:0]    clr_idx_q;
	logic [CMD_W-1:0]     cmd_q;
	logic [SET_AW-1:0]    set_q;
	logic [WAY_IN_W-1:0]  way_q;
	logic [MASK_W-1:0]    mask_q;
	trk_row_t             rd_trk_q;
	cnt_row_t             rd_cnt_q;
	rnk_row_t             rd_rnk_q;
	logic [WAY_BITS-1:0]  idx_q;
	logic                 found_q;
	logic [WAY_BITS-1:0]  best_way_q;
	logic [COUNT_BITS-1:0] best_cnt_q;
	logic [WAY_BITS-1:0]  best_rnk_q;
	logic [WAY_IN_W-1:0]  res_way_q;
	logic                 res_conf_q;
	logic [LINE_COUNT_W-1:0] res_cnt_q;
	logic                 out_valid_q;
	logic [WAY_IN_W-1:0]  out_way_q;
	logic                 out_conf_q;
	logic [LINE_COUNT_W-1:0] out_cnt_q;

	logic [SET_IN_W-1:0]  set_red;
	logic [SET_AW-1:0]    rd_addr;
	logic                 rd_en;
	logic                 way_ok;
	logic [WAY_BITS-1:0]  way_idx;
	logic [WAY_BITS-1:0]  old_rnk;
	logic                 inv_found;
	logic [WAY_BITS-1:0]  inv_way;
	logic                 mem_we;
	logic [SET_AW-1:0]    mem_wa;
	trk_row_t             wr_trk;
	cnt_row_t             wr_cnt;
	rnk_row_t             wr_rnk;
	logic                 cand_better;
	logic [WAY_BITS-1:0]  fin_way;
	logic                 fin_found;
	logic [WAY_BITS-1:0]  scan_way;
	logic                 scan_last;
	logic                 out_free;
	logic                 done_wait;
	logic [(1<<WAY_BITS)-1:0] rank_seen;

	// set index reduced modulo NUM_SETS by conditional subtraction
	always_comb begin
		set_red = req.set_addr;
		for (int k = SET_IN_W; k >= 0; k--) begin
			if ((NUM_SETS << k) < (1 << SET_IN_W)) begin
				if (32'(set_red) >= (NUM_SETS << k))
					set_red = set_red - SET_IN_W'(NUM_SETS << k);
			end
		end
	end

	assign rd_addr = SET_AW'(set_red);
	assign rd_en   = req.valid && req.ready;
	assign way_ok  = 32'(way_q) < NUM_WAYS;
	assign way_idx = WAY_BITS'(way_q);
	assign old_rnk = rd_rnk_q[way_idx];

	// first invalid way of the mask
	always_comb begin
		inv_found = 1'b0;
		inv_way   = '0;
		for (int i = MASK_LIM - 1; i >= 0; i--) begin
			if (!mask_q[i]) begin
				inv_found = 1'b1;
				inv_way   = WAY_BITS'(i);
			end
		end
	end

	// row update for touch and reset, reset row during the clearing pass
	always_comb begin
		wr_trk = rd_trk_q;
		wr_cnt = rd_cnt_q;
		wr_rnk = rd_rnk_q;
		if (state_q == ST_CLEAR) begin
			wr_trk = '0;
			wr_cnt = '0;
			for (int i = 0; i < NUM_WAYS; i++)
				wr_rnk[i] = WAY_BITS'(i);
		end else if (cmd_q == CMD_TOUCH) begin
			wr_trk[way_idx] = 1'b1;
			if (!rd_trk_q[way_idx])
				wr_cnt[way_idx] = COUNT_BITS'(1);
			else if (rd_cnt_q[way_idx] != '1)
				wr_cnt[way_idx] = rd_cnt_q[way_idx] + COUNT_BITS'(1);
			for (int i = 0; i < NUM_WAYS; i++) begin
				if (rd_rnk_q[i] < old_rnk)
					wr_rnk[i] = rd_rnk_q[i] + WAY_BITS'(1);
			end
			wr_rnk[way_idx] = '0;
		end else if (cmd_q == CMD_RESET) begin
			wr_trk[way_idx] = 1'b0;
			wr_cnt[way_idx] = '0;
		end
	end

	assign mem_we = (state_q == ST_CLEAR) ||
		(state_q == ST_EXEC && way_ok && (cmd_q == CMD_TOUCH || cmd_q == CMD_RESET));
	assign mem_wa = (state_q == ST_CLEAR) ? clr_idx_q : set_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_trk[mem_wa] <= wr_trk;
			mem_cnt[mem_wa] <= wr_cnt;
			mem_rnk[mem_wa] <= wr_rnk;
		end
		if (rd_en) begin
			rd_trk_q <= mem_trk[rd_addr];
			rd_cnt_q <= mem_cnt[rd_addr];
			rd_rnk_q <= mem_rnk[rd_addr];
		end
	end

	// shared comparator: lower count wins, older rank wins a tie
	assign cand_better = rd_trk_q[idx_q] && (!found_q || rd_cnt_q[idx_q] < best_cnt_q ||
		(rd_cnt_q[idx_q] == best_cnt_q && rd_rnk_q[idx_q] > best_rnk_q));
	assign fin_way   = cand_better ? idx_q : best_way_q;
	assign fin_found = found_q || cand_better;
	assign scan_way  = fin_found ? fin_way : '0;
	assign scan_last = idx_q == WAY_BITS'(NUM_WAYS - 1);
	assign out_free  = !out_valid_q || rsp.ready;
	assign done_wait = state_q == ST_DONE && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (rsp.valid && rsp.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + SET_AW'(1);
					if (clr_idx_q == SET_AW'(NUM_SETS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (rd_en)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (cmd_q == CMD_VICTIM && !inv_found)
						state_q <= ST_SCAN;
					else
						state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (scan_last)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// request capture, scan registers and result payload
	always_ff @(posedge clk) begin
		if (rd_en) begin
			cmd_q  <= req.cmd;
			set_q  <= rd_addr;
			way_q  <= req.way;
			mask_q <= req.valid_mask;
		end
		if (state_q == ST_EXEC) begin
			idx_q      <= '0;
			found_q    <= 1'b0;
			best_way_q <= '0;
			best_cnt_q <= '0;
			best_rnk_q <= '0;
			if (cmd_q == CMD_VICTIM) begin
				res_way_q  <= WAY_IN_W'(inv_way);
				res_cnt_q  <= clip(rd_cnt_q[inv_way]);
				res_conf_q <= !inv_found;
			end else begin
				res_way_q  <= way_q;
				res_conf_q <= 1'b0;
				res_cnt_q  <= way_ok ? clip(wr_cnt[way_idx]) : '0;
			end
		end
		if (state_q == ST_SCAN) begin
			idx_q <= idx_q + WAY_BITS'(1);
			if (cand_better) begin
				found_q    <= 1'b1;
				best_way_q <= idx_q;
				best_cnt_q <= rd_cnt_q[idx_q];
				best_rnk_q <= rd_rnk_q[idx_q];
			end
			if (scan_last) begin
				res_way_q <= WAY_IN_W'(scan_way);
				res_cnt_q <= clip(rd_cnt_q[scan_way]);
			end
		end
		if (state_q == ST_DONE && out_free) begin
			out_way_q  <= res_way_q;
			out_conf_q <= res_conf_q;
			out_cnt_q  <= res_cnt_q;
		end
	end

	assign req.ready      = state_q == ST_IDLE;
	assign rsp.valid      = out_valid_q;
	assign rsp.victim_way = out_way_q;
	assign rsp.conflict   = out_conf_q;
	assign rsp.line_count = out_cnt_q;

	always_comb begin
		rank_seen = '0;
		for (int i = 0; i < NUM_WAYS; i++)
			rank_seen[rd_rnk_q[i]] = 1'b1;
	end

	`ASSERT_IMPLIES(a_rank_perm, state_q == ST_EXEC, &rank_seen[NUM_WAYS-1:0], "rank row broken")
	`ASSERT_IMPLIES(a_scan_idx, state_q == ST_SCAN, 32'(idx_q) < NUM_WAYS, "scan index too high")
	`ASSERT_NEXT(a_accept_exec, req.valid && req.ready, state_q == ST_EXEC, "transaction lost")
	`ASSERT_NEXT(a_done_stall, done_wait, state_q == ST_DONE, "result dropped")

endmodule

// ===== tb/sv/lfu_lru_tiebreak_replacement_tb.sv =====
module lfu_lru_tiebreak_replacement_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lfu_pkg::*;

	localparam int SETS = NUM_SETS_DEF;
	localparam int WAYS = NUM_WAYS_DEF;
	localparam logic [LINE_COUNT_W-1:0] COUNT_SAT = '1;
	localparam logic [CMD_W-1:0] CMD_UNDEF = 2'd3;
	localparam int HEAVY_TOUCHES = 40;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [SET_IN_W-1:0] set_addr;
		logic [WAY_IN_W-1:0] way;
		logic [MASK_W-1:0]   valid_mask;
		logic                hold;
	} lfu_req_t;

	typedef struct packed {
		logic [WAY_IN_W-1:0]     victim_way;
		logic                    conflict;
		logic [LINE_COUNT_W-1:0] line_count;
	} lfu_rsp_t;

	logic clk;
	logic arst_n;

	lfu_req_if req_bus ();
	lfu_rsp_if rsp_bus ();

	lfu_lru_tiebreak_replacement i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	// shadow of the per-way replacement state
	logic                    way_tracked [SETS][WAYS];
	logic [LINE_COUNT_W-1:0] way_uses    [SETS][WAYS];
	logic [WAY_IN_W-1:0]     way_age     [SETS][WAYS];

	lfu_req_t req_q[$];
	lfu_rsp_t outcome_q[$];
	lfu_req_t cur_req;

	int acc_total;
	int n_pushed;
	int n_rcvd;
	int n_fail;
	int calm_from;
	int gap_cnt;
	int stall_cnt;

	function automatic lfu_rsp_t predict_access(lfu_req_t it);
		lfu_rsp_t r;
		int s;
		int w;
		int best;
		int old;
		logic found;
		s = it.set_addr % SETS;
		w = it.way;
		r.victim_way = it.way;
		r.conflict = 1'b0;
		r.line_count = '0;
		if (it.cmd == CMD_VICTIM) begin
			r.conflict = 1'b1;
			for (int i = WAYS - 1; i >= 0; i--) begin
				if (!it.valid_mask[i]) begin
					r.conflict = 1'b0;
					r.victim_way = WAY_IN_W'(i);
				end
			end
			if (r.conflict) begin
				found = 1'b0;
				best = 0;
				for (int i = 0; i < WAYS; i++) begin
					if (way_tracked[s][i] && (!found || way_uses[s][i] < way_uses[s][best] ||
						(way_uses[s][i] == way_uses[s][best] &&
						way_age[s][i] > way_age[s][best]))) begin
						best = i;
						found = 1'b1;
					end
				end
				r.victim_way = WAY_IN_W'(best);
			end
			r.line_count = way_uses[s][r.victim_way];
		end else if (w < WAYS) begin
			if (it.cmd == CMD_TOUCH) begin
				if (!way_tracked[s][w]) begin
					way_tracked[s][w] = 1'b1;
					way_uses[s][w] = LINE_COUNT_W'(1);
				end else if (way_uses[s][w] != COUNT_SAT) begin
					way_uses[s][w] = way_uses[s][w] + 1'b1;
				end
				old = int'(way_age[s][w]);
				for (int i = 0; i < WAYS; i++) begin
					if (int'(way_age[s][i]) < old)
						way_age[s][i] = way_age[s][i] + 1'b1;
				end
				way_age[s][w] = '0;
			end else if (it.cmd == CMD_RESET) begin
				way_tracked[s][w] = 1'b0;
				way_uses[s][w] = '0;
			end
			r.line_count = way_uses[s][w];
		end
		return r;
	endfunction

	task automatic add_req(input logic [CMD_W-1:0] c, input int s, input int w,
		input logic [MASK_W-1:0] m, input logic h);
		lfu_req_t it;
		it.cmd = c;
		it.set_addr = SET_IN_W'(s);
		it.way = WAY_IN_W'(w);
		it.valid_mask = m;
		it.hold = h;
		req_q.push_back(it);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// stimulus
	initial begin
		logic [SET_IN_W-1:0] hot [4];
		logic [MASK_W-1:0] m;
		logic [CMD_W-1:0] c;
		int r;
		int s;

		add_req(CMD_VICTIM, 0, 0, 8'h00, 1'b0);
		add_req(CMD_VICTIM, 0, 7, 8'hff, 1'b0);
		add_req(CMD_VICTIM, 0, 3, 8'h7f, 1'b0);
		add_req(CMD_UNDEF, 63, 7, 8'hff, 1'b0);
		repeat (3) add_req(CMD_TOUCH, 63, 7, 8'h00, 1'b0);
		add_req(CMD_TOUCH, 63, 0, 8'h00, 1'b0);
		repeat (3) add_req(CMD_TOUCH, 63, 2, 8'hff, 1'b0);
		add_req(CMD_VICTIM, 63, 5, 8'hff, 1'b0);
		add_req(CMD_RESET, 63, 0, 8'h00, 1'b0);
		add_req(CMD_VICTIM, 63, 0, 8'hff, 1'b0);
		add_req(CMD_UNDEF, 63, 2, 8'h00, 1'b0);
		add_req(CMD_VICTIM, 63, 1, 8'hfe, 1'b0);
		add_req(CMD_RESET, 0, 7, 8'hff, 1'b0);
		add_req(CMD_TOUCH, 21, 5, 8'h55, 1'b0);
		add_req(CMD_VICTIM, 21, 0, 8'hff, 1'b0);
		add_req(CMD_TOUCH, 42, 1, 8'haa, 1'b0);
		add_req(CMD_TOUCH, 42, 6, 8'h00, 1'b0);
		add_req(CMD_VICTIM, 42, 0, 8'hbf, 1'b1);
		add_req(CMD_VICTIM, 42, 0, 8'hff, 1'b0);

		for (int n = 0; n < 1900; n++) begin
			if (n % 100 == 0) begin
				foreach (hot[k])
					hot[k] = SET_IN_W'($urandom_range(0, SETS - 1));
			end
			s = ($urandom_range(0, 9) < 7) ? hot[$urandom_range(0, 3)] :
				$urandom_range(0, 63);
			r = $urandom_range(0, 99);
			if (r < 48)
				c = CMD_TOUCH;
			else if (r < 78)
				c = CMD_VICTIM;
			else if (r < 90)
				c = CMD_RESET;
			else
				c = CMD_UNDEF;
			r = $urandom_range(0, 99);
			if (r < 55)
				m = 8'hff;
			else if (r < 75)
				m = ~(8'h01 << $urandom_range(0, 7));
			else
				m = MASK_W'($urandom_range(0, 255));
			add_req(c, s, $urandom_range(0, 7), m, $urandom_range(0, 199) == 0);
		end

		// pump one count well above the rest, then compare it against a low one
		calm_from = req_q.size() - 100;
		add_req(CMD_RESET, 9, 4, 8'h00, 1'b1);
		add_req(CMD_TOUCH, 9, 1, 8'h00, 1'b0);
		add_req(CMD_TOUCH, 9, 1, 8'h00, 1'b0);
		repeat (HEAVY_TOUCHES) add_req(CMD_TOUCH, 9, 4, 8'h00, 1'b0);
		add_req(CMD_VICTIM, 9, 0, 8'hff, 1'b0);
		add_req(CMD_RESET, 9, 1, 8'h00, 1'b0);
		add_req(CMD_VICTIM, 9, 0, 8'hff, 1'b0);
		add_req(CMD_UNDEF, 9, 4, 8'h00, 1'b0);
		add_req(CMD_RESET, 9, 4, 8'h00, 1'b0);
		add_req(CMD_VICTIM, 9, 0, 8'hff, 1'b0);
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
			req_bus.cmd <= '0;
			req_bus.set_addr <= '0;
			req_bus.way <= '0;
			req_bus.valid_mask <= '0;
			acc_total = 0;
			n_pushed <= 0;
			gap_cnt = 0;
			for (int s = 0; s < SETS; s++) begin
				for (int w = 0; w < WAYS; w++) begin
					way_tracked[s][w] = 1'b0;
					way_uses[s][w] = '0;
					way_age[s][w] = WAY_IN_W'(w);
				end
			end
		end else begin
			if (req_bus.valid && req_bus.ready) begin
				outcome_q.push_back(predict_access(cur_req));
				acc_total++;
				n_pushed <= acc_total;
			end
			if (!(req_bus.valid && !req_bus.ready)) begin
				if (gap_cnt > 0) begin
					gap_cnt--;
					req_bus.valid <= 1'b0;
				end else if (req_q.size() != 0 && (!req_q[0].hold || n_rcvd == acc_total)) begin
					if (acc_total < calm_from && (acc_total / 128) % 4 != 3 &&
						$urandom_range(0, 5) == 0) begin
						gap_cnt = $urandom_range(0, 12);
						req_bus.valid <= 1'b0;
					end else begin
						cur_req = req_q.pop_front();
						req_bus.cmd <= cur_req.cmd;
						req_bus.set_addr <= cur_req.set_addr;
						req_bus.way <= cur_req.way;
						req_bus.valid_mask <= cur_req.valid_mask;
						req_bus.valid <= 1'b1;
					end
				end else begin
					req_bus.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		lfu_rsp_t got;
		lfu_rsp_t want;
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
			n_rcvd <= 0;
			n_fail = 0;
			stall_cnt = 0;
		end else begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				got.victim_way = rsp_bus.victim_way;
				got.conflict = rsp_bus.conflict;
				got.line_count = rsp_bus.line_count;
				if (n_rcvd >= n_pushed) begin
					n_fail++;
					$display("%0t: unexpected transaction: way %0d conflict %0d count %0d",
						$time, got.victim_way, got.conflict, got.line_count);
				end else begin
					want = outcome_q[n_rcvd];
					if (got.victim_way !== want.victim_way || got.conflict !== want.conflict ||
						got.line_count !== want.line_count) begin
						n_fail++;
						$display("%0t: transaction %0d expected %0d %0d %0d got %0d %0d %0d",
							$time, n_rcvd, want.victim_way, want.conflict, want.line_count,
							got.victim_way, got.conflict, got.line_count);
					end
					n_rcvd <= n_rcvd + 1;
				end
			end
			if (stall_cnt > 0) begin
				stall_cnt--;
				rsp_bus.ready <= 1'b0;
			end else if (n_rcvd < calm_from && (n_rcvd / 128) % 4 != 1 &&
				$urandom_range(0, 7) == 0) begin
				stall_cnt = $urandom_range(0, 12);
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= 1'b1;
			end
		end
	end

	initial begin
		@(posedge arst_n);
		do
			@(negedge clk);
		while (req_q.size() != 0 || req_bus.valid || n_rcvd != n_pushed);
		repeat (40) @(posedge clk);
		@(negedge clk);
		if (n_fail == 0 && n_rcvd == n_pushed)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#10ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/lfu_pkg.sv
src/lfu_if.sv
src/lfu_lru_tiebreak_replacement.sv
tb/sv/lfu_lru_tiebreak_replacement_tb.sv
